[rtl/fpp_pkg.sv]
// fpp_pkg: shared types, constants and the crc-16/arc byte update for the frame parser
// used by framed_packet_parser_crc16.sv
package fpp_pkg;

  localparam logic [7:0]  MARK_HEAD = 8'h3C;
  localparam logic [7:0]  MARK_TAIL = 8'h3E;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [10:0] {
    ST_HEAD_L  = 11'b000_0000_0001,
    ST_HEAD_H  = 11'b000_0000_0010,
    ST_CHANNEL = 11'b000_0000_0100,
    ST_FLAGS   = 11'b000_0000_1000,
    ST_LEN_L   = 11'b000_0001_0000,
    ST_LEN_H   = 11'b000_0010_0000,
    ST_PAYLOAD = 11'b000_0100_0000,
    ST_CRC_L   = 11'b000_1000_0000,
    ST_CRC_H   = 11'b001_0000_0000,
    ST_TAIL_L  = 11'b010_0000_0000,
    ST_TAIL_H  = 11'b100_0000_0000
  } fpp_state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [7:0]  channel;
    logic [7:0]  frame_flags;
    logic [15:0] frame_length;
    logic        frame_ok;
  } fpp_result_t;

  // reflected crc-16, eight shift-xor steps for one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/fpp_stream_if.sv]
// fpp_in_if / fpp_out_if: valid-ready channels of the frame parser
// standalone, no package dependency
interface fpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [7:0]  channel;
  logic [7:0]  frame_flags;
  logic [15:0] frame_length;
  logic        frame_ok;

  modport source (output valid, output kind, output data_byte, output channel,
                  output frame_flags, output frame_length, output frame_ok,
                  input ready);
  modport sink   (input valid, input kind, input data_byte, input channel,
                  input frame_flags, input frame_length, input frame_ok,
                  output ready);
endinterface

[rtl/framed_packet_parser_crc16.sv]
// framed_packet_parser_crc16: byte-stream parser for '<<' ch flags len payload crc '>>' frames
// depends on fpp_pkg.sv and fpp_stream_if.sv
//
// usage:
// in_ch takes one received byte per word (valid/ready). out_ch gives one word for
// every payload byte (kind 0, data_byte set) and one end-of-frame report after the
// second tail byte (kind 1, frame_ok set when both tail marks and the crc-16/arc
// of the payload match). header bytes, crc bytes and the first tail byte give no word.
// a byte that is not '<' in either head position drops back to hunting for '<'.
// a frame with zero length goes from the length bytes straight to the crc bytes.
// result words are registered in the output register, or in the skid word while that one is stalled.
// throughput: one byte per cycle while in_ch.ready is high; the crc update for a byte is
// combinational logic between the input byte and the running crc register.
// stall: an output register plus one skid word hold results while out_ch.ready is low,
// so in_ch.ready only drops once both are full; nothing is lost or repeated.
// reset (rst_n low, synchronous): parser hunts for the first head byte, both
// result words are emptied.
module framed_packet_parser_crc16 (
  input  logic           clk,
  input  logic           rst_n,
  fpp_in_if.sink         in_ch,
  fpp_out_if.source      out_ch
);
  import fpp_pkg::*;

  fpp_state_t  state_r, state_nxt;
  logic [7:0]  held_channel_r, held_channel_nxt;
  logic [7:0]  held_flags_r, held_flags_nxt;
  logic [15:0] held_length_r, held_length_nxt;
  logic [15:0] bytes_seen_r, bytes_seen_nxt;
  logic [15:0] received_crc_r, received_crc_nxt;
  logic [15:0] running_crc_r, running_crc_nxt;
  logic        tail_ok_r, tail_ok_nxt;

  fpp_result_t out_r, skid_r, res;
  logic        out_valid_r, skid_valid_r;
  logic        res_valid;
  logic        in_fire, out_fire;
  logic [7:0]  b;
  logic [15:0] seen_inc;

  assign in_fire  = in_ch.valid & in_ch.ready;
  assign out_fire = out_valid_r & out_ch.ready;
  assign b        = in_ch.rx_byte;
  assign seen_inc = bytes_seen_r + 16'd1;

  always_comb begin
    state_nxt        = state_r;
    held_channel_nxt = held_channel_r;
    held_flags_nxt   = held_flags_r;
    held_length_nxt  = held_length_r;
    bytes_seen_nxt   = bytes_seen_r;
    received_crc_nxt = received_crc_r;
    running_crc_nxt  = running_crc_r;
    tail_ok_nxt      = tail_ok_r;
    res_valid        = 1'b0;
    res.kind         = KIND_DATA;
    res.data_byte    = 8'h00;
    res.channel      = held_channel_r;
    res.frame_flags  = held_flags_r;
    res.frame_length = held_length_r;
    res.frame_ok     = 1'b0;
    unique case (state_r)
      ST_HEAD_H: begin
        state_nxt = (b == MARK_HEAD) ? ST_CHANNEL : ST_HEAD_L;
      end
      ST_CHANNEL: begin
        held_channel_nxt = b;
        state_nxt        = ST_FLAGS;
      end
      ST_FLAGS: begin
        held_flags_nxt = b;
        state_nxt      = ST_LEN_L;
      end
      ST_LEN_L: begin
        held_length_nxt = {8'h00, b};
        state_nxt       = ST_LEN_H;
      end
      ST_LEN_H: begin
        held_length_nxt = {b, held_length_r[7:0]};
        bytes_seen_nxt  = 16'd0;
        running_crc_nxt = 16'd0;
        tail_ok_nxt     = 1'b1;
        state_nxt       = ({b, held_length_r[7:0]} == 16'd0) ? ST_CRC_L : ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        running_crc_nxt = crc16_byte(running_crc_r, b);
        bytes_seen_nxt  = seen_inc;
        if (seen_inc == held_length_r) begin
          state_nxt = ST_CRC_L;
        end
        res_valid     = 1'b1;
        res.kind      = KIND_DATA;
        res.data_byte = b;
      end
      ST_CRC_L: begin
        received_crc_nxt = {8'h00, b};
        state_nxt        = ST_CRC_H;
      end
      ST_CRC_H: begin
        received_crc_nxt = {b, received_crc_r[7:0]};
        state_nxt        = ST_TAIL_L;
      end
      ST_TAIL_L: begin
        if (b != MARK_TAIL) begin
          tail_ok_nxt = 1'b0;
        end
        state_nxt = ST_TAIL_H;
      end
      ST_TAIL_H: begin
        state_nxt    = ST_HEAD_L;
        res_valid    = 1'b1;
        res.kind     = KIND_REPORT;
        res.frame_ok = tail_ok_r & (b == MARK_TAIL) & (received_crc_r == running_crc_r);
      end
      default: begin
        // waiting for the first head byte, also any stray code
        state_nxt = (b == MARK_HEAD) ? ST_HEAD_H : ST_HEAD_L;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_HEAD_L;
      held_channel_r <= 8'h00;
      held_flags_r   <= 8'h00;
      held_length_r  <= 16'd0;
      bytes_seen_r   <= 16'd0;
      received_crc_r <= 16'd0;
      running_crc_r  <= 16'd0;
      tail_ok_r      <= 1'b1;
    end else if (in_fire) begin
      state_r        <= state_nxt;
      held_channel_r <= held_channel_nxt;
      held_flags_r   <= held_flags_nxt;
      held_length_r  <= held_length_nxt;
      bytes_seen_r   <= bytes_seen_nxt;
      received_crc_r <= received_crc_nxt;
      running_crc_r  <= running_crc_nxt;
      tail_ok_r      <= tail_ok_nxt;
    end
  end

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_fire) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (in_fire && res_valid) begin
        if (!out_valid_r || out_ch.ready) begin
          out_r       <= res;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= res;
          skid_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ch.ready         = ~skid_valid_r;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_r.kind;
  assign out_ch.data_byte    = out_r.data_byte;
  assign out_ch.channel      = out_r.channel;
  assign out_ch.frame_flags  = out_r.frame_flags;
  assign out_ch.frame_length = out_r.frame_length;
  assign out_ch.frame_ok     = out_r.frame_ok;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held while output register empty");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PAYLOAD) |-> (bytes_seen_r < held_length_r))
    else $error("payload count ran past declared length");

  a_report_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && state_r == ST_TAIL_H) |=> (out_valid_r && state_r == ST_HEAD_L))
    else $error("end of frame report not registered");

  a_report_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_REPORT) |-> (out_r.data_byte == 8'h00))
    else $error("report word carries a data byte");

  a_data_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_DATA) |-> !out_r.frame_ok)
    else $error("payload word has ok bit set");

endmodule
